// File: rtl/cssh_pkg.sv
// ----------------------------------------------------------------------------
// cssh_pkg
// shared types and constants of the closest swept-sphere hit search
// ----------------------------------------------------------------------------
package cssh_pkg;

    localparam int SLOT_W = 6;
    localparam int TIME_W = 32;
    localparam int FRAC_T = 16;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;

    // per-slot solver sequence
    typedef enum logic [3:0] {
        S_IDLE,
        S_PROD,
        S_SUM,
        S_MLOAD,
        S_MUL,
        S_DISC,
        S_SQRT,
        S_NUM,
        S_DIV,
        S_SAT,
        S_DONE
    } t_solve_st;

    // back end sequence
    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_WRITE,
        B_FETCH,
        B_CHECK,
        B_SOLVE,
        B_NEXT,
        B_RESULT
    } t_back_st;

    // classification of a queued request
    typedef struct packed {
        logic is_write;
        logic wr_ok;
    } t_cls;

    // result of one slot solve
    typedef struct packed {
        logic                      done;
        logic                      unb;
        logic                      ovl;
        logic signed [TIME_W-1:0]  t;
    } t_slot_res;

    // back end status
    typedef struct packed {
        logic clearing;
        logic solving;
    } t_back_stat;

endpackage

// File: rtl/cssh_if.sv
// ----------------------------------------------------------------------------
// cssh request and response channels
// valid/ready channels carrying one request or one response
// ----------------------------------------------------------------------------
interface cssh_req_if #(parameter int CW = 24);
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [5:0]           slot;
    logic signed [CW-1:0] pos_x;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] vel_x;
    logic signed [CW-1:0] vel_y;
    logic signed [CW-1:0] vel_z;
    logic [CW-2:0]        radius;
    logic                 eligible;
    logic                 skip_valid;
    logic [5:0]           skip_slot;

    modport source (
        output valid, operation, slot, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               radius, eligible, skip_valid, skip_slot,
        input  ready
    );
    modport sink (
        input  valid, operation, slot, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               radius, eligible, skip_valid, skip_slot,
        output ready
    );
endinterface

interface cssh_rsp_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic [5:0]         hit_slot;
    logic signed [31:0] hit_time;
    logic               time_unbounded;

    modport source (
        output valid, found, hit_slot, hit_time, time_unbounded,
        input  ready
    );
    modport sink (
        input  valid, found, hit_slot, hit_time, time_unbounded,
        output ready
    );
endinterface

// File: rtl/cssh_front.sv
// ----------------------------------------------------------------------------
// cssh_front
// accepts requests, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module cssh_front import cssh_pkg::*; #(
    parameter int MAX_SPHERES = 64,
    parameter int CW          = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cssh_req_if.sink          i_req,
    cssh_req_if.source        o_q,
    output t_cls              o_cls
);

    localparam int PLW = 7 * CW + 14;

    logic [PLW-1:0] r_pl [2];
    t_cls           r_cl [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;
    logic [PLW-1:0] w_pl;
    t_cls           w_cl;

    assign i_req.ready = (r_cnt != 2'd2);
    assign o_q.valid   = (r_cnt != 2'd0);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = o_q.valid && o_q.ready;

    assign w_pl = {i_req.operation, i_req.slot, i_req.pos_x, i_req.pos_y, i_req.pos_z,
                   i_req.vel_x, i_req.vel_y, i_req.vel_z, i_req.radius,
                   i_req.eligible, i_req.skip_valid, i_req.skip_slot};

    // writes beyond the table are dropped
    always_comb begin
        w_cl.is_write = (i_req.operation == OP_WRITE);
        w_cl.wr_ok    = w_cl.is_write && (32'(i_req.slot) < MAX_SPHERES);
    end

    assign {o_q.operation, o_q.slot, o_q.pos_x, o_q.pos_y, o_q.pos_z,
            o_q.vel_x, o_q.vel_y, o_q.vel_z, o_q.radius,
            o_q.eligible, o_q.skip_valid, o_q.skip_slot} = r_pl[r_rp];
    assign o_cls = r_cl[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_pl[r_wp] <= w_pl;
            r_cl[r_wp] <= w_cl;
        end
    end

endmodule

// File: rtl/cssh_solve.sv
// ----------------------------------------------------------------------------
// cssh_solve
// swept-sphere time of contact for one slot, serial multiply, root, divide
// ----------------------------------------------------------------------------
module cssh_solve import cssh_pkg::*; #(
    parameter int CW = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [3*CW-1:0] i_qpos,
    input  logic [3*CW-1:0] i_qvel,
    input  logic [CW-2:0]   i_qrad,
    input  logic [3*CW-1:0] i_spos,
    input  logic [3*CW-1:0] i_svel,
    input  logic [CW-2:0]   i_srad,
    output t_slot_res       o_res
);

    localparam int DW   = CW + 1;
    localparam int AW   = 2 * CW + 3;
    localparam int HW   = AW + 1;
    localparam int DDW  = 2 * AW + 2;
    localparam int SQW  = AW + 1;
    localparam int RMW  = AW + 4;
    localparam int NSW  = AW + 3;
    localparam int NUMW = AW + 2 + FRAC_T;
    localparam int CNTW = $clog2(NUMW + 1);

    t_solve_st r_st, n_st;

    logic signed [CW-1:0]   w_qp [3], w_qv [3], w_sp [3], w_sv [3];
    logic signed [DW-1:0]   r_dp [3], r_dv [3];
    logic [CW-1:0]          r_rs;
    logic signed [2*DW-1:0] r_paa [3], r_ppp [3], r_pap [3];
    logic [2*CW-1:0]        r_rr;
    logic [AW-1:0]          r_a;
    logic signed [HW-1:0]   r_h, r_c;
    logic [AW-1:0]          r_m1a, r_m1h, r_m1l, r_m2a, r_m2h, r_m2l;
    logic [DDW-1:0]         r_sqx;
    logic [RMW-1:0]         r_rem;
    logic [SQW-1:0]         r_root;
    logic                   r_neg;
    logic [NUMW-1:0]        r_num;
    logic [AW-1:0]          r_drem;
    logic [CNTW-1:0]        r_cnt;
    logic                   r_unb, r_ovl;
    logic signed [TIME_W-1:0] r_t;

    logic signed [HW-1:0]   w_a, w_pp, w_h, w_c, w_habs, w_cabs;
    logic [AW:0]            w_s1, w_s2;
    logic [2*AW-1:0]        w_hh, w_ac;
    logic                   w_dneg;
    logic [2*AW:0]          w_d;
    logic [RMW-1:0]         w_remsh, w_trial;
    logic                   w_sge;
    logic signed [NSW-1:0]  w_n, w_nabs;
    logic [AW:0]            w_rem2, w_rsub;
    logic                   w_dge;
    logic                   w_cnt_end;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_qp[k] = $signed(i_qpos[k*CW +: CW]);
            w_qv[k] = $signed(i_qvel[k*CW +: CW]);
            w_sp[k] = $signed(i_spos[k*CW +: CW]);
            w_sv[k] = $signed(i_svel[k*CW +: CW]);
        end
    end

    // a = dv.dv, h = dp.dv, c = dp.dp - R*R
    assign w_a  = HW'(r_paa[0]) + HW'(r_paa[1]) + HW'(r_paa[2]);
    assign w_pp = HW'(r_ppp[0]) + HW'(r_ppp[1]) + HW'(r_ppp[2]);
    assign w_h  = HW'(r_pap[0]) + HW'(r_pap[1]) + HW'(r_pap[2]);
    assign w_c  = w_pp - $signed(HW'(r_rr));

    assign w_habs = (r_h < 0) ? -r_h : r_h;
    assign w_cabs = (r_c < 0) ? -r_c : r_c;

    // shift-add multipliers, one bit a cycle
    assign w_s1 = {1'b0, r_m1h} + (r_m1l[0] ? {1'b0, r_m1a} : '0);
    assign w_s2 = {1'b0, r_m2h} + (r_m2l[0] ? {1'b0, r_m2a} : '0);

    assign w_hh   = {r_m1h, r_m1l};
    assign w_ac   = {r_m2h, r_m2l};
    assign w_dneg = !r_ovl && (w_hh < w_ac);
    assign w_d    = r_ovl ? ({1'b0, w_hh} + {1'b0, w_ac}) : ({1'b0, w_hh} - {1'b0, w_ac});

    // restoring square root, two radicand bits a cycle
    assign w_remsh = {r_rem[RMW-3:0], r_sqx[DDW-1 -: 2]};
    assign w_trial = RMW'({r_root, 2'b01});
    assign w_sge   = (w_remsh >= w_trial);

    // numerator -h - s
    assign w_n    = -NSW'(r_h) - $signed(NSW'(r_root));
    assign w_nabs = (w_n < 0) ? -w_n : w_n;

    // restoring divide, one quotient bit a cycle
    assign w_rem2 = {r_drem, r_num[NUMW-1]};
    assign w_rsub = w_rem2 - {1'b0, r_a};
    assign w_dge  = (w_rem2 >= {1'b0, r_a});

    assign w_cnt_end = (r_cnt == CNTW'(1));

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:  if (i_start) n_st = S_PROD;
            S_PROD:  n_st = S_SUM;
            S_SUM:   n_st = S_MLOAD;
            S_MLOAD: n_st = (r_a == '0) ? S_DONE : S_MUL;
            S_MUL:   if (w_cnt_end) n_st = S_DISC;
            S_DISC:  n_st = w_dneg ? S_DONE : S_SQRT;
            S_SQRT:  if (w_cnt_end) n_st = S_NUM;
            S_NUM:   n_st = S_DIV;
            S_DIV:   if (w_cnt_end) n_st = S_SAT;
            S_SAT:   n_st = S_DONE;
            S_DONE:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_res.done = (r_st == S_DONE);
        o_res.unb  = r_unb;
        o_res.ovl  = r_ovl;
        o_res.t    = r_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= S_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_dp[k] <= DW'(w_qp[k]) - DW'(w_sp[k]);
                    r_dv[k] <= DW'(w_qv[k]) - DW'(w_sv[k]);
                end
                r_rs <= CW'(i_qrad) + CW'(i_srad);
            end
            S_PROD: begin
                for (int k = 0; k < 3; k++) begin
                    r_paa[k] <= r_dv[k] * r_dv[k];
                    r_ppp[k] <= r_dp[k] * r_dp[k];
                    r_pap[k] <= r_dp[k] * r_dv[k];
                end
                r_rr <= r_rs * r_rs;
            end
            S_SUM: begin
                r_a   <= w_a[AW-1:0];
                r_h   <= w_h;
                r_c   <= w_c;
                r_ovl <= (w_c < 0);
            end
            S_MLOAD: begin
                r_m1a <= w_habs[AW-1:0];
                r_m1l <= w_habs[AW-1:0];
                r_m1h <= '0;
                r_m2a <= r_a;
                r_m2l <= w_cabs[AW-1:0];
                r_m2h <= '0;
                r_cnt <= CNTW'(AW);
                r_unb <= 1'b1;
                r_t   <= '0;
            end
            S_MUL: begin
                r_m1h <= w_s1[AW:1];
                r_m1l <= {w_s1[0], r_m1l[AW-1:1]};
                r_m2h <= w_s2[AW:1];
                r_m2l <= {w_s2[0], r_m2l[AW-1:1]};
                r_cnt <= r_cnt - CNTW'(1);
            end
            S_DISC: begin
                r_sqx  <= DDW'(w_d);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNTW'(SQW);
            end
            S_SQRT: begin
                r_sqx  <= {r_sqx[DDW-3:0], 2'b00};
                r_rem  <= w_sge ? (w_remsh - w_trial) : w_remsh;
                r_root <= {r_root[SQW-2:0], w_sge};
                r_cnt  <= r_cnt - CNTW'(1);
            end
            S_NUM: begin
                r_neg  <= (w_n < 0);
                r_num  <= {w_nabs[AW+1:0], {FRAC_T{1'b0}}};
                r_drem <= '0;
                r_cnt  <= CNTW'(NUMW);
            end
            S_DIV: begin
                r_drem <= w_dge ? w_rsub[AW-1:0] : w_rem2[AW-1:0];
                r_num  <= {r_num[NUMW-2:0], w_dge};
                r_cnt  <= r_cnt - CNTW'(1);
            end
            S_SAT: begin
                r_unb <= 1'b0;
                if (r_neg) begin
                    if (r_num > NUMW'(33'h1_0000_0000 >> 1)) r_t <= TIME_MIN;
                    else                                    r_t <= -$signed(r_num[TIME_W-1:0]);
                end else begin
                    if (r_num > NUMW'(TIME_MAX)) r_t <= TIME_MAX;
                    else                         r_t <= $signed(r_num[TIME_W-1:0]);
                end
            end
            S_DONE: ;
            default: ;
        endcase
    end

endmodule

// File: rtl/cssh_back.sv
// ----------------------------------------------------------------------------
// cssh_back
// slot table, scan sequencer, best-hit tracking and response register
// ----------------------------------------------------------------------------
module cssh_back import cssh_pkg::*; #(
    parameter int MAX_SPHERES = 64,
    parameter int CW          = 24
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cssh_req_if.sink        i_q,
    input  t_cls            i_cls,
    cssh_rsp_if.source      o_rsp,
    output logic            o_start,
    output logic [3*CW-1:0] o_qpos,
    output logic [3*CW-1:0] o_qvel,
    output logic [CW-2:0]   o_qrad,
    output logic [3*CW-1:0] o_spos,
    output logic [3*CW-1:0] o_svel,
    output logic [CW-2:0]   o_srad,
    input  t_slot_res       i_sres,
    output t_back_stat      o_stat
);

    localparam int IW = $clog2(MAX_SPHERES);
    localparam int XW = (IW > SLOT_W) ? IW : SLOT_W;
    localparam int EW = 7 * CW;

    t_back_st r_st, n_st;

    logic [EW-1:0] r_mem [MAX_SPHERES];
    logic [EW-1:0] r_rd;
    logic [IW-1:0] r_idx;

    logic                     r_found, r_bunb;
    logic [IW-1:0]            r_best;
    logic signed [TIME_W-1:0] r_bt;

    logic                     r_ovld, r_ofound, r_ounb;
    logic [SLOT_W-1:0]        r_oslot;
    logic signed [TIME_W-1:0] r_otime;

    logic          w_we, w_last, w_ofree, w_elig, w_skip, w_better;
    logic [IW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [XW-1:0] w_slotx, w_idxx, w_bestx;

    assign w_slotx = XW'(i_q.slot);
    assign w_idxx  = XW'(r_idx);
    assign w_bestx = XW'(r_best);
    assign w_last  = (r_idx == IW'(MAX_SPHERES - 1));
    assign w_ofree = !r_ovld || o_rsp.ready;

    assign w_elig = r_rd[EW-1];
    assign w_skip = i_q.skip_valid && (XW'(i_q.skip_slot) == w_idxx);

    assign w_better = (!i_sres.unb && !i_sres.t[TIME_W-1] && (r_bunb || (i_sres.t < r_bt)))
                      || i_sres.ovl;

    assign o_qpos = {i_q.pos_z, i_q.pos_y, i_q.pos_x};
    assign o_qvel = {i_q.vel_z, i_q.vel_y, i_q.vel_x};
    assign o_qrad = i_q.radius;
    assign o_spos = r_rd[3*CW-1:0];
    assign o_svel = r_rd[6*CW-1:3*CW];
    assign o_srad = r_rd[7*CW-2:6*CW];

    assign o_rsp.valid          = r_ovld;
    assign o_rsp.found          = r_ofound;
    assign o_rsp.hit_slot       = r_oslot;
    assign o_rsp.hit_time       = r_otime;
    assign o_rsp.time_unbounded = r_ounb;

    // table write port: clearing pass or write request
    always_comb begin
        w_we    = (r_st == B_CLEAR) || ((r_st == B_WRITE) && i_cls.wr_ok);
        w_waddr = (r_st == B_CLEAR) ? r_idx : w_slotx[IW-1:0];
        w_wdata = (r_st == B_CLEAR) ? '0 :
                  {i_q.eligible, i_q.radius, i_q.vel_z, i_q.vel_y, i_q.vel_x,
                   i_q.pos_z, i_q.pos_y, i_q.pos_x};
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
        r_rd <= r_mem[r_idx];
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            B_CLEAR:  if (w_last) n_st = B_IDLE;
            B_IDLE:   if (i_q.valid) n_st = i_cls.is_write ? B_WRITE : B_FETCH;
            B_WRITE:  n_st = B_RESULT;
            B_FETCH:  n_st = B_CHECK;
            B_CHECK:  n_st = (w_elig && !w_skip) ? B_SOLVE : B_NEXT;
            B_SOLVE:  if (i_sres.done) n_st = B_NEXT;
            B_NEXT:   n_st = w_last ? B_RESULT : B_FETCH;
            B_RESULT: if (w_ofree) n_st = B_IDLE;
            default:  n_st = B_IDLE;
        endcase
    end

    always_comb begin
        o_start         = (r_st == B_CHECK) && w_elig && !w_skip;
        i_q.ready       = (r_st == B_RESULT) && w_ofree;
        o_stat.clearing = (r_st == B_CLEAR);
        o_stat.solving  = (r_st == B_SOLVE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= B_CLEAR;
            r_idx  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (((r_st == B_CLEAR) || (r_st == B_NEXT)) && !w_last)
                r_idx <= r_idx + IW'(1);
            else if ((r_st == B_CLEAR) || (r_st == B_IDLE))
                r_idx <= '0;
            if ((r_st == B_RESULT) && w_ofree) r_ovld <= 1'b1;
            else if (o_rsp.ready)              r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            B_IDLE: begin
                r_found <= 1'b0;
                r_best  <= '0;
                r_bt    <= '0;
                r_bunb  <= !i_cls.is_write;
            end
            B_SOLVE: begin
                if (i_sres.done && w_better) begin
                    r_found <= 1'b1;
                    r_best  <= r_idx;
                    r_bt    <= i_sres.t;
                    r_bunb  <= i_sres.unb;
                end
            end
            B_RESULT: begin
                if (w_ofree) begin
                    r_ofound <= r_found;
                    r_oslot  <= r_found ? w_bestx[SLOT_W-1:0] : '0;
                    r_otime  <= r_bunb ? TIME_MAX : r_bt;
                    r_ounb   <= r_bunb;
                end
            end
            B_CLEAR, B_WRITE, B_FETCH, B_CHECK, B_NEXT: ;
            default: ;
        endcase
    end

endmodule

// File: rtl/closest_swept_sphere_hit_top.sv
// ----------------------------------------------------------------------------
// closest_swept_sphere_hit_top
// closest swept-sphere hit search over a table of moving spheres
// ----------------------------------------------------------------------------
// after reset a clearing pass over all MAX_SPHERES slots runs before any request
// a write request passes the idle, write and result states once it reaches the queue head
// a query walks every slot: a skipped or ineligible slot passes fetch, check and
// next; a solved slot also waits for the serial multiply, root and divide
// one request is worked at a time; a 2-entry queue and the response register
// let the input and output sides stall on their own
module closest_swept_sphere_hit_top import cssh_pkg::*; #(
    parameter int MAX_SPHERES = 64,
    parameter int COORD_WIDTH = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cssh_req_if.sink    i_req,
    cssh_rsp_if.source  o_rsp
);

    // queue between the classifying front end and the back end
    cssh_req_if #(.CW(COORD_WIDTH)) q_if ();

    t_cls                     w_cls;
    t_slot_res                w_sres;
    t_back_stat               w_stat;
    logic                     w_start;
    logic [3*COORD_WIDTH-1:0] w_qpos, w_qvel, w_spos, w_svel;
    logic [COORD_WIDTH-2:0]   w_qrad, w_srad;

    // front end: accept, classify, queue
    cssh_front #(
        .MAX_SPHERES (MAX_SPHERES),
        .CW          (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_q     (q_if),
        .o_cls   (w_cls)
    );

    // back end: slot table, scan and response register
    cssh_back #(
        .MAX_SPHERES (MAX_SPHERES),
        .CW          (COORD_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q_if),
        .i_cls   (w_cls),
        .o_rsp   (o_rsp),
        .o_start (w_start),
        .o_qpos  (w_qpos),
        .o_qvel  (w_qvel),
        .o_qrad  (w_qrad),
        .o_spos  (w_spos),
        .o_svel  (w_svel),
        .o_srad  (w_srad),
        .i_sres  (w_sres),
        .o_stat  (w_stat)
    );

    // per-slot time of contact
    cssh_solve #(
        .CW (COORD_WIDTH)
    ) u_solve (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_qpos  (w_qpos),
        .i_qvel  (w_qvel),
        .i_qrad  (w_qrad),
        .i_spos  (w_spos),
        .i_svel  (w_svel),
        .i_srad  (w_srad),
        .o_res   (w_sres)
    );

    // a solve only finishes while the back end waits for it
    a_done_in_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sres.done |-> w_stat.solving)
        else $error("solve finished outside of a slot solve");

    // no request leaves the queue during the clearing pass
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.clearing |-> !q_if.ready)
        else $error("queue popped during clearing pass");

    // a full queue always offers its head
    a_full_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> q_if.valid)
        else $error("input stalled with an empty queue");

    // every solve start is followed by the back end waiting for the slot solve
    a_start_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_stat.solving)
        else $error("slot solve start not followed by wait");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives write and query requests into closest_swept_sphere_hit_top, predicts
// each response with an exact integer swept-sphere solver and checks every
// field; directed table first, then random traffic under four idling phases
// ----------------------------------------------------------------------------
module testbench;
    import cssh_pkg::*;

    localparam int CW         = 24;
    localparam int N_SLOTS    = 64;
    localparam int N_RANDOM   = 400;
    localparam int MAX_ELIG   = 8;       // keeps query scans short
    localparam int IDLE_LIMIT = 60000;   // one full query plus worst stalls, several times over
    localparam int TAIL_WAIT  = 200;

    // idling patterns
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef logic signed [127:0] t_wide;

    // one request as the sender drives it
    typedef struct {
        logic                 operation;
        logic [5:0]           slot;
        logic signed [CW-1:0] pos [3];
        logic signed [CW-1:0] vel [3];
        logic [CW-2:0]        radius;
        logic                 eligible;
        logic                 skip_valid;
        logic [5:0]           skip_slot;
    } t_sphere_req;

    typedef struct packed {
        logic               found;
        logic [5:0]         hit_slot;
        logic signed [31:0] hit_time;
        logic               time_unbounded;
    } t_hit_rsp;

    // directed row: the response is typed in only where chk is set
    typedef struct {
        t_sphere_req req;
        bit          chk;
        t_hit_rsp    rsp;
    } t_table_row;

    typedef struct {
        logic signed [31:0] t;
        logic               unb;
        logic               ovl;
    } t_slot_time;

    logic i_clk;
    logic i_rst_n;

    cssh_req_if #(.CW(CW)) req_ch ();
    cssh_rsp_if            rsp_ch ();

    closest_swept_sphere_hit_top #(
        .MAX_SPHERES (N_SLOTS),
        .COORD_WIDTH (CW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // shadow copy of the sphere table
    logic signed [CW-1:0] tbl_pos [N_SLOTS][3];
    logic signed [CW-1:0] tbl_vel [N_SLOTS][3];
    logic [CW-2:0]        tbl_rad [N_SLOTS];
    logic                 tbl_elig [N_SLOTS];

    t_hit_rsp   pending_hits [$];
    t_table_row dir_rows [$];
    int         fail_cnt;
    int         idle_mode;
    int         quiet_cycles;
    bit         req_fire;
    bit         rsp_fire;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic t_wide floor_root(t_wide x);
        t_wide r, b;
        r = 0;
        b = t_wide'(1) <<< 124;
        while (b > x) b = b >>> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - r - b;
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // earlier touching time of the query sphere against one table slot
    function automatic t_slot_time sweep_time(t_sphere_req q, int i);
        t_slot_time res;
        t_wide dp, dv, a, h, pp, rr, c, disc, s, num, quo;
        a  = 0;
        h  = 0;
        pp = 0;
        for (int k = 0; k < 3; k++) begin
            dp = t_wide'(q.pos[k]) - t_wide'(tbl_pos[i][k]);
            dv = t_wide'(q.vel[k]) - t_wide'(tbl_vel[i][k]);
            a  += dv * dv;
            h  += dp * dv;
            pp += dp * dp;
        end
        rr = t_wide'({1'b0, q.radius}) + t_wide'({1'b0, tbl_rad[i]});
        c  = pp - rr * rr;
        res.ovl = (c < 0);
        res.unb = 1'b1;
        res.t   = 0;
        if (a == 0) return res;
        disc = h * h - a * c;
        if (disc < 0) return res;
        s   = floor_root(disc);
        num = (-h - s) * 65536;
        quo = num / a;   // truncates toward zero
        if (quo > t_wide'(TIME_MAX)) quo = t_wide'(TIME_MAX);
        if (quo < t_wide'(TIME_MIN)) quo = t_wide'(TIME_MIN);
        res.t   = quo[31:0];
        res.unb = 1'b0;
        return res;
    endfunction

    // applies a write request to the shadow table; returns the response of any request
    function automatic t_hit_rsp closest_hit(t_sphere_req q);
        t_hit_rsp   r;
        t_slot_time st;
        logic signed [31:0] best_t;
        logic best_unb;
        r = '{found: 1'b0, hit_slot: '0, hit_time: '0, time_unbounded: 1'b0};
        if (q.operation == OP_WRITE) begin
            tbl_pos[q.slot]  = q.pos;
            tbl_vel[q.slot]  = q.vel;
            tbl_rad[q.slot]  = q.radius;
            tbl_elig[q.slot] = q.eligible;
            return r;
        end
        best_t   = 0;
        best_unb = 1'b1;
        for (int i = 0; i < N_SLOTS; i++) begin
            if (!tbl_elig[i]) continue;
            if (q.skip_valid && q.skip_slot == i) continue;
            st = sweep_time(q, i);
            if ((!st.unb && st.t >= 0 && (best_unb || st.t < best_t)) || st.ovl) begin
                r.found    = 1'b1;
                r.hit_slot = i[5:0];
                best_t     = st.t;
                best_unb   = st.unb;
            end
        end
        r.hit_time       = best_unb ? TIME_MAX : best_t;
        r.time_unbounded = best_unb;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    function automatic bit idle_now(bit sender);
        if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 21;
        if (sender && idle_mode == IDLE_SEND) return $urandom_range(0, 99) < 62;
        if (!sender && idle_mode == IDLE_RECV) return $urandom_range(0, 99) < 62;
        return 1'b0;
    endfunction

    // drives one request, waits for its handshake and records its expected response
    task automatic send_request(t_sphere_req q, bit chk, t_hit_rsp typed);
        t_hit_rsp predicted;
        while (idle_now(1'b1)) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= q.operation;
        req_ch.slot       <= q.slot;
        req_ch.pos_x      <= q.pos[0];
        req_ch.pos_y      <= q.pos[1];
        req_ch.pos_z      <= q.pos[2];
        req_ch.vel_x      <= q.vel[0];
        req_ch.vel_y      <= q.vel[1];
        req_ch.vel_z      <= q.vel[2];
        req_ch.radius     <= q.radius;
        req_ch.eligible   <= q.eligible;
        req_ch.skip_valid <= q.skip_valid;
        req_ch.skip_slot  <= q.skip_slot;
        do @(posedge i_clk); while (!req_ch.ready);
        predicted = closest_hit(q);
        if (chk && predicted != typed) begin
            $display("%0t table row disagrees with predictor: typed %p predicted %p",
                     $time, typed, predicted);
            fail_cnt++;
        end
        pending_hits = {pending_hits, (chk ? typed : predicted)};
    endtask

    task automatic drain_hits();
        while (pending_hits.size() != 0) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [CW-1:0] rand_coord(bit full, int span);
        if (full) return CW'($urandom());
        return CW'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_table_row mk_row(logic op, int slot, int px, int py, int pz,
                                          int vx, int vy, int vz, int rad, int elig,
                                          int skv, int sks, int chk, t_hit_rsp rsp);
        t_table_row row;
        row.req.operation  = op;
        row.req.slot       = 6'(slot);
        row.req.pos        = '{CW'(px), CW'(py), CW'(pz)};
        row.req.vel        = '{CW'(vx), CW'(vy), CW'(vz)};
        row.req.radius     = (CW-1)'(rad);
        row.req.eligible   = 1'(elig);
        row.req.skip_valid = 1'(skv);
        row.req.skip_slot  = 6'(sks);
        row.chk            = 1'(chk);
        row.rsp            = rsp;
        return row;
    endfunction

    function automatic void add_row(t_table_row row);
        dir_rows = {dir_rows, row};
    endfunction

    // ------------------------------------------------------------------
    // response side: random stalls and field-by-field compare
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_hit_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t unexpected response: expected none actual %0b %0d %0d %0b",
                         $time, rsp_ch.found, rsp_ch.hit_slot, rsp_ch.hit_time,
                         rsp_ch.time_unbounded);
                fail_cnt++;
            end else begin
                want = pending_hits.pop_front();
                if (rsp_ch.found !== want.found) begin
                    $display("%0t found: expected %0b actual %0b",
                             $time, want.found, rsp_ch.found);
                    fail_cnt++;
                end
                if (rsp_ch.hit_slot !== want.hit_slot) begin
                    $display("%0t hit_slot: expected %0d actual %0d",
                             $time, want.hit_slot, rsp_ch.hit_slot);
                    fail_cnt++;
                end
                if (rsp_ch.hit_time !== want.hit_time) begin
                    $display("%0t hit_time: expected %0d actual %0d",
                             $time, want.hit_time, rsp_ch.hit_time);
                    fail_cnt++;
                end
                if (rsp_ch.time_unbounded !== want.time_unbounded) begin
                    $display("%0t time_unbounded: expected %0b actual %0b",
                             $time, want.time_unbounded, rsp_ch.time_unbounded);
                    fail_cnt++;
                end
            end
        end
        rsp_ch.ready <= !idle_now(1'b0);
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        req_fire = req_ch.valid && req_ch.ready;
        rsp_fire = rsp_ch.valid && rsp_ch.ready;
        if (req_fire || rsp_fire || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        t_hit_rsp    nil;
        t_hit_rsp    no_hit;
        t_sphere_req q;
        int          n_elig;
        bit          full;
        int          span;
        int          anchor;

        nil          = '{found: 1'b0, hit_slot: '0, hit_time: '0, time_unbounded: 1'b0};
        no_hit       = '{found: 1'b0, hit_slot: '0, hit_time: TIME_MAX, time_unbounded: 1'b1};
        fail_cnt     = 0;
        idle_mode    = IDLE_NONE;
        for (int i = 0; i < N_SLOTS; i++) tbl_elig[i] = 1'b0;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_WRITE;
        req_ch.slot       = '0;
        req_ch.pos_x      = '0;
        req_ch.pos_y      = '0;
        req_ch.pos_z      = '0;
        req_ch.vel_x      = '0;
        req_ch.vel_y      = '0;
        req_ch.vel_z      = '0;
        req_ch.radius     = '0;
        req_ch.eligible   = 1'b0;
        req_ch.skip_valid = 1'b0;
        req_ch.skip_slot  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table after reset: nothing to hit
        add_row(mk_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, no_hit));
        // extreme spheres at both ends of the table
        add_row(mk_row(OP_WRITE, 0, 8388607, -8388608, 0, 8388607, -8388608, 0,
                       8388607, 1, 0, 0, 1, nil));
        add_row(mk_row(OP_WRITE, 63, -8388608, 8388607, 8388607, 0, 8388607,
                       -8388608, 0, 1, 0, 0, 1, nil));
        // overlap with zero relative velocity wins with an unbounded time
        add_row(mk_row(OP_QUERY, 0, 8388607, -8388608, 0, 8388607, -8388608, 0,
                       0, 0, 0, 0, 0, nil));
        add_row(mk_row(OP_QUERY, 0, 8388607, -8388608, 0, 8388607, -8388608, 0,
                       0, 0, 1, 0, 0, nil));
        add_row(mk_row(OP_QUERY, 0, -8388608, 8388607, 8388607, -1, 5, 7,
                       8388607, 1, 1, 63, 0, nil));
        add_row(mk_row(OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, nil));
        add_row(mk_row(OP_WRITE, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, nil));
        // one resting sphere: approach, retreat, no motion, miss
        add_row(mk_row(OP_WRITE, 5, 0, 0, 0, 0, 0, 0, 256, 1, 0, 0, 1, nil));
        add_row(mk_row(OP_QUERY, 0, 2560, 0, 0, -256, 0, 0, 256, 0, 0, 0, 0, nil));
        add_row(mk_row(OP_QUERY, 0, 2560, 0, 0, 256, 0, 0, 256, 0, 0, 0, 0, nil));
        add_row(mk_row(OP_QUERY, 0, 2560, 0, 0, 0, 0, 0, 256, 0, 0, 0, 1, no_hit));
        add_row(mk_row(OP_QUERY, 0, 2560, 2048, 0, -256, 0, 0, 0, 0, 0, 0, 1,
                       no_hit));
        // far and slow: time saturates at the top
        add_row(mk_row(OP_QUERY, 0, 8388607, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0, nil));
        // nearer sphere in the path, then skipped, then skip flag off
        add_row(mk_row(OP_WRITE, 9, 1280, 0, 0, 0, 0, 0, 256, 1, 0, 0, 1, nil));
        add_row(mk_row(OP_QUERY, 0, 2560, 0, 0, -256, 0, 0, 256, 0, 0, 0, 0, nil));
        add_row(mk_row(OP_QUERY, 0, 2560, 0, 0, -256, 0, 0, 256, 0, 1, 9, 0, nil));
        add_row(mk_row(OP_QUERY, 0, 2560, 0, 0, -256, 0, 0, 256, 0, 0, 9, 0, nil));
        add_row(mk_row(OP_WRITE, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, nil));
        add_row(mk_row(OP_WRITE, 9, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, nil));

        foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rsp);

        // random traffic, one idling pattern per phase
        for (int phase = IDLE_NONE; phase <= IDLE_BOTH; phase++) begin
            // sender holds off until every response is back
            drain_hits();
            idle_mode = phase;
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                n_elig = 0;
                for (int i = 0; i < N_SLOTS; i++) n_elig += tbl_elig[i];
                full   = ($urandom_range(0, 99) < 15);
                span   = $urandom_range(0, 1) ? 512 : 4096;
                anchor = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 1000000)) - 500000;
                q.operation  = $urandom_range(0, 1) ? OP_QUERY : OP_WRITE;
                q.slot       = 6'($urandom_range(0, N_SLOTS - 1));
                for (int k = 0; k < 3; k++) begin
                    q.pos[k] = CW'(anchor + rand_coord(full, span));
                    q.vel[k] = rand_coord(full, span / 8);
                end
                q.radius     = full ? (CW-1)'($urandom()) : (CW-1)'($urandom_range(0, span / 2));
                q.eligible   = (n_elig < MAX_ELIG) ? 1'($urandom_range(0, 1)) : 1'b0;
                q.skip_valid = 1'($urandom_range(0, 1));
                q.skip_slot  = 6'($urandom_range(0, N_SLOTS - 1));
                send_request(q, 1'b0, nil);
            end
        end
        req_ch.valid <= 1'b0;

        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
